/* design/cph_pkg.sv */
// shared types, codes and constants for the color palette histogram
`default_nettype none
package cph_pkg;

    localparam int PALETTE_SIZE_DEF = 256;

    typedef enum logic [1:0] {
        REQ_PIXEL = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_MATCH       = 3'd0,
        ST_ADDED       = 3'd1,
        ST_DROPPED     = 3'd2,
        ST_READ_OK     = 3'd3,
        ST_READ_UNUSED = 3'd4,
        ST_CLEARED     = 3'd5
    } t_status;

    // which values go into the entry fields of the result
    typedef enum logic [2:0] {
        ENT_HIT    = 3'd0,
        ENT_APPEND = 3'd1,
        ENT_DROP   = 3'd2,
        ENT_READ   = 3'd3,
        ENT_UNUSED = 3'd4,
        ENT_ZERO   = 3'd5
    } t_ent_src;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] pixel_color;
        logic [7:0]  read_index;
        logic        last_pixel;
    } t_cph_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  entry_index;
        logic [31:0] entry_color;
        logic [31:0] entry_count;
        logic [8:0]  colors_used;
        logic        image_done;
    } t_cph_out;

    typedef struct packed {
        logic     take;
        logic     scan_start;
        logic     scan_run;
        logic     hit_write;
        logic     append;
        logic     rd_issue;
        logic     clr;
        logic     ent_load;
        t_ent_src ent_src;
        t_status  status;
        logic     load_out;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic hit;
        logic scan_done;
        logic full;
        logic rd_ok;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

/* design/color_palette_histogram.sv */
// top level of the color palette histogram
// Keeps a palette of up to PALETTE_SIZE distinct 32-bit colors with a saturating
// pixel count per color, in a memory with one write port and one registered read
// port. One item is worked at a time. A pixel item scans the used entries one per
// cycle through the memory read port; a read item reads its entry through the
// same port unless the index is unused, and a clear item resets the used count.
// The result sits in an output register, so the next item is taken while it
// waits. Reset empties the palette at once; no clearing pass is needed.
`default_nettype none
module color_palette_histogram
    import cph_pkg::*;
#(
    parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_valid,
    output logic     o_ready,
    input  t_cph_in  i_item,
    output logic     o_valid,
    input  wire      i_ready,
    output t_cph_out o_item
);

    t_cmd  cmd;
    t_stat st;

    cph_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    cph_dpath #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_item  (o_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_cmd   (cmd),
        .o_st    (st)
    );

endmodule
`default_nettype wire

/* design/cph_ctrl.sv */
// controller state machine: sequences the scan, update, read and result handoff
`default_nettype none
module cph_ctrl
    import cph_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    output logic  o_ready,
    input  t_stat i_st,
    output t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_DECODE  = 6'b000010,
        S_SCAN    = 6'b000100,
        S_HIT     = 6'b001000,
        S_RD_DATA = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_st.req)
                    REQ_PIXEL: begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                    REQ_READ: begin
                        if (i_st.rd_ok) begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = S_RD_DATA;
                        end else begin
                            o_cmd.ent_load = 1'b1;
                            o_cmd.ent_src  = ENT_UNUSED;
                            o_cmd.status   = ST_READ_UNUSED;
                            n_state        = S_DONE;
                        end
                    end
                    REQ_CLEAR: begin
                        o_cmd.clr      = 1'b1;
                        o_cmd.ent_load = 1'b1;
                        o_cmd.ent_src  = ENT_ZERO;
                        o_cmd.status   = ST_CLEARED;
                        n_state        = S_DONE;
                    end
                    // unused code: no result
                    default: n_state = S_IDLE;
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_st.hit) begin
                    o_cmd.ent_load = 1'b1;
                    o_cmd.ent_src  = ENT_HIT;
                    o_cmd.status   = ST_MATCH;
                    n_state        = S_HIT;
                end else if (i_st.scan_done) begin
                    o_cmd.ent_load = 1'b1;
                    if (i_st.full) begin
                        o_cmd.ent_src = ENT_DROP;
                        o_cmd.status  = ST_DROPPED;
                    end else begin
                        o_cmd.append  = 1'b1;
                        o_cmd.ent_src = ENT_APPEND;
                        o_cmd.status  = ST_ADDED;
                    end
                    n_state = S_DONE;
                end
            end
            S_HIT: begin
                o_cmd.hit_write = 1'b1;
                n_state         = S_DONE;
            end
            S_RD_DATA: begin
                o_cmd.ent_load = 1'b1;
                o_cmd.ent_src  = ENT_READ;
                o_cmd.status   = ST_READ_OK;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

/* design/cph_dpath.sv */
// datapath: palette memory, used counter, scan pipeline and result register
`default_nettype none
module cph_dpath
    import cph_pkg::*;
#(
    parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  t_cph_in  i_item,
    output t_cph_out o_item,
    output logic     o_valid,
    input  wire      i_ready,
    input  t_cmd     i_cmd,
    output t_stat    o_st
);

    localparam int IW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int CW = $clog2(PALETTE_SIZE + 1);

    // each word holds {color, count}
    logic [63:0]   r_mem [PALETTE_SIZE];
    logic [63:0]   r_rdata;

    t_cph_in       r_req;
    logic [CW-1:0] r_used;
    logic [CW-1:0] r_scan_addr;
    logic          r_pend;
    logic [IW-1:0] r_pend_idx;
    logic [IW-1:0] r_wr_idx;
    t_status       r_status;
    logic [7:0]    r_ent_idx;
    logic [31:0]   r_ent_col;
    logic [31:0]   r_ent_cnt;
    t_cph_out      r_out;
    logic          r_out_vld;

    logic [IW-1:0] rd_addr;
    logic [IW-1:0] ridx_addr;
    logic [31:0]   inc_cnt;
    logic          full;
    logic          scan_more;

    assign ridx_addr = IW'(r_req.read_index);
    assign rd_addr   = i_cmd.rd_issue ? ridx_addr : r_scan_addr[IW-1:0];
    assign inc_cnt   = (r_rdata[31:0] == 32'hFFFF_FFFF) ? r_rdata[31:0]
                                                       : r_rdata[31:0] + 32'd1;
    assign full      = (r_used == CW'(PALETTE_SIZE));
    assign scan_more = (r_scan_addr < r_used);

    assign o_st.req       = t_req'(r_req.req_type);
    assign o_st.hit       = r_pend && (r_rdata[63:32] == r_req.pixel_color);
    assign o_st.scan_done = !r_pend && !scan_more;
    assign o_st.full      = full;
    assign o_st.rd_ok     = (32'(r_req.read_index) < 32'(r_used));
    assign o_st.out_free  = !r_out_vld || i_ready;

    // palette memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.hit_write) begin
            r_mem[r_wr_idx] <= {r_ent_col, r_ent_cnt};
        end else if (i_cmd.append) begin
            r_mem[r_used[IW-1:0]] <= {r_req.pixel_color, 32'd1};
        end
        r_rdata <= r_mem[rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_used <= '0;
            end else if (i_cmd.append) begin
                r_used <= r_used + CW'(1);
            end
            if (i_cmd.scan_start) begin
                r_pend <= 1'b0;
            end else if (i_cmd.scan_run) begin
                r_pend <= scan_more;
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_req <= i_item;
        end
        if (i_cmd.scan_start) begin
            r_scan_addr <= '0;
        end else if (i_cmd.scan_run && scan_more) begin
            r_scan_addr <= r_scan_addr + CW'(1);
        end
        if (i_cmd.scan_run) begin
            r_pend_idx <= r_scan_addr[IW-1:0];
        end
        if (i_cmd.ent_load) begin
            r_status <= i_cmd.status;
            case (i_cmd.ent_src)
                ENT_HIT: begin
                    r_wr_idx  <= r_pend_idx;
                    r_ent_idx <= 8'(r_pend_idx);
                    r_ent_col <= r_req.pixel_color;
                    r_ent_cnt <= inc_cnt;
                end
                ENT_APPEND: begin
                    r_ent_idx <= 8'(r_used);
                    r_ent_col <= r_req.pixel_color;
                    r_ent_cnt <= 32'd1;
                end
                ENT_DROP: begin
                    r_ent_idx <= 8'd0;
                    r_ent_col <= r_req.pixel_color;
                    r_ent_cnt <= 32'd0;
                end
                ENT_READ: begin
                    r_ent_idx <= r_req.read_index;
                    r_ent_col <= r_rdata[63:32];
                    r_ent_cnt <= r_rdata[31:0];
                end
                ENT_UNUSED: begin
                    r_ent_idx <= r_req.read_index;
                    r_ent_col <= 32'd0;
                    r_ent_cnt <= 32'd0;
                end
                default: begin
                    r_ent_idx <= 8'd0;
                    r_ent_col <= 32'd0;
                    r_ent_cnt <= 32'd0;
                end
            endcase
        end
        if (i_cmd.load_out) begin
            r_out.status      <= r_status;
            r_out.entry_index <= r_ent_idx;
            r_out.entry_color <= r_ent_col;
            r_out.entry_count <= r_ent_cnt;
            r_out.colors_used <= 9'(r_used);
            r_out.image_done  <= (r_req.req_type == REQ_PIXEL) ? r_req.last_pixel : 1'b0;
        end
    end

    assign o_item  = r_out;
    assign o_valid = r_out_vld;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(PALETTE_SIZE))
        else $error("palette use count beyond size");

    a_no_append_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> !full)
        else $error("append into a full palette");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan_run && o_st.hit) |-> (CW'(r_pend_idx) < r_used))
        else $error("match on an unused entry");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.hit_write && i_cmd.append))
        else $error("two palette writes in one cycle");

endmodule
`default_nettype wire
